/* hw/rtl/i2a_pkg.sv */
// Shared constants, types and character helpers for the integer-to-ASCII converter.
`default_nettype none
package i2a_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int PTR_DIGITS  = 16;
  // floor(W * log10(2)) + 1 decimal digits cover 2^W - 1
  localparam int DEC_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int NUM_CELLS   = (DEC_DIGITS > PTR_DIGITS) ? DEC_DIGITS : PTR_DIGITS;
  localparam int REM_W       = $clog2(NUM_CELLS + 1);
  localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);

  localparam logic [1:0] MODE_SDEC = 2'd0;
  localparam logic [1:0] MODE_UDEC = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;
  localparam logic [1:0] MODE_PTR  = 2'd3;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_A_OFS = 8'h57;  // 'a' - 10

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_CONV,
    CELL_UP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     dec;
  } cell_ctrl_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_A_OFS + {4'd0, d};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/i2a_cell.sv */
// One digit cell: shift-and-add-3 step during conversion, digit shift-up during output.
`default_nettype none
module i2a_cell (
  input  wire logic              clk,
  input  wire i2a_pkg::cell_ctrl_t ctrl,
  input  wire logic              bit_in,
  input  wire logic [3:0]        digit_in,
  output logic                   bit_out,
  output logic [3:0]             digit
);

  logic [3:0] adj;

  // decimal digits of 5 or more get +3 before doubling; hex nibbles shift plain
  always_comb begin
    if (ctrl.dec && (digit >= 4'd5)) begin
      adj = digit + 4'd3;
    end else begin
      adj = digit;
    end
  end

  assign bit_out = adj[3];

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      i2a_pkg::CELL_HOLD:  digit <= digit;
      i2a_pkg::CELL_CLEAR: digit <= 4'd0;
      i2a_pkg::CELL_CONV:  digit <= {adj[2:0], bit_in};
      i2a_pkg::CELL_UP:    digit <= digit_in;
      default:             digit <= digit;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/integer_to_ascii_radix_core.sv */
// Integer to ASCII text converter: sequencer, bit shifter and a chain of digit cells.
// Steps: shift all 64 value bits through the digit cells, then the prefix ("0x" in pointer mode,
// "-" for negative signed values), then leading zeros are dropped, then one character per cycle
// while out_ready allows. One item at a time: in_ready is high only in idle, to which the
// sequencer returns once the final character is loaded into the one-character output register.
// Reset clears the state, out_valid and pfx_second; digit cells and data registers are not reset.
`default_nettype none
module integer_to_ascii_radix_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [63:0] value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       char_out,
  output logic             last
);

  localparam int W  = i2a_pkg::VALUE_WIDTH;
  localparam int NC = i2a_pkg::NUM_CELLS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_PFX,
    S_SKIP,
    S_EMIT
  } state_t;

  state_t                     state;
  logic [1:0]                 mode_q;
  logic                       neg;
  logic                       pfx_second;
  logic [W-1:0]               sr;
  logic [i2a_pkg::CNT_W-1:0]  bit_cnt;
  logic [i2a_pkg::REM_W-1:0]  rem;

  logic [W-1:0]               v_in;
  logic                       neg_in;
  logic                       in_fire;
  logic                       free;
  logic                       load;
  logic                       is_ptr;
  logic                       skip;
  logic [3:0]                 top;
  i2a_pkg::cell_ctrl_t        ctrl;

  logic [3:0] digits [NC];
  logic       bits   [NC+1];

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign free     = !out_valid || out_ready;
  assign is_ptr   = (mode_q == i2a_pkg::MODE_PTR);
  assign top      = digits[NC-1];

  assign v_in   = value[W-1:0];
  assign neg_in = (mode == i2a_pkg::MODE_SDEC) && v_in[W-1];

  // a character enters the output register this cycle
  always_comb begin
    load = 1'b0;
    if (free) begin
      if (state == S_PFX) begin
        load = is_ptr || neg;
      end else if (state == S_EMIT) begin
        load = 1'b1;
      end
    end
  end

  // pointer mode drops the cells above its fixed 16 digits; others drop leading zeros
  always_comb begin
    if (is_ptr) begin
      skip = (rem > i2a_pkg::REM_W'(i2a_pkg::PTR_DIGITS));
    end else begin
      skip = (top == 4'd0) && (rem > i2a_pkg::REM_W'(1));
    end
  end

  always_comb begin
    ctrl.dec = (mode_q == i2a_pkg::MODE_SDEC) || (mode_q == i2a_pkg::MODE_UDEC);
    ctrl.op  = i2a_pkg::CELL_HOLD;
    unique case (state)
      S_IDLE:  if (in_fire) ctrl.op = i2a_pkg::CELL_CLEAR;
      S_CONV:  ctrl.op = i2a_pkg::CELL_CONV;
      S_SKIP:  if (skip) ctrl.op = i2a_pkg::CELL_UP;
      S_EMIT:  if (free) ctrl.op = i2a_pkg::CELL_UP;
      default: ctrl.op = i2a_pkg::CELL_HOLD;
    endcase
  end

  assign bits[0] = sr[W-1];

  for (genvar g = 0; g < NC; g++) begin : g_cell
    i2a_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bit_in   (bits[g]),
      .digit_in ((g == 0) ? 4'd0 : digits[(g == 0) ? 0 : g-1]),
      .bit_out  (bits[g+1]),
      .digit    (digits[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      pfx_second <= 1'b0;
    end else begin
      out_valid <= load || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            mode_q     <= mode;
            neg        <= neg_in;
            sr         <= neg_in ? (~v_in + W'(1)) : v_in;
            bit_cnt    <= i2a_pkg::CNT_W'(W);
            rem        <= i2a_pkg::REM_W'(NC);
            pfx_second <= 1'b0;
            state      <= S_CONV;
          end
        end
        S_CONV: begin
          sr      <= {sr[W-2:0], 1'b0};
          bit_cnt <= bit_cnt - i2a_pkg::CNT_W'(1);
          if (bit_cnt == i2a_pkg::CNT_W'(1)) begin
            state <= S_PFX;
          end
        end
        S_PFX: begin
          if (is_ptr) begin
            if (free) begin
              last       <= 1'b0;
              char_out   <= pfx_second ? i2a_pkg::CH_X : i2a_pkg::CH_ZERO;
              pfx_second <= 1'b1;
              if (pfx_second) begin
                state <= S_SKIP;
              end
            end
          end else if (neg) begin
            if (free) begin
              last      <= 1'b0;
              char_out  <= i2a_pkg::CH_MINUS;
              state     <= S_SKIP;
            end
          end else begin
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (skip) begin
            rem <= rem - i2a_pkg::REM_W'(1);
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (free) begin
            char_out  <= i2a_pkg::hex_char(top);
            last      <= (rem == i2a_pkg::REM_W'(1));
            rem       <= rem - i2a_pkg::REM_W'(1);
            if (rem == i2a_pkg::REM_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_SKIP || state == S_EMIT) |-> (rem != '0))
    else $error("digit count ran out before the final character");

  a_conv_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_PFX || state == S_SKIP || state == S_EMIT) |-> (bit_cnt == '0))
    else $error("output started before conversion finished");

  a_ptr_width: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && is_ptr) |-> (rem <= i2a_pkg::REM_W'(i2a_pkg::PTR_DIGITS)))
    else $error("pointer text longer than 16 digits");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && free && rem == i2a_pkg::REM_W'(1))
      |=> (state == S_IDLE && out_valid && last))
    else $error("final character not marked or sequencer not back to idle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(char_out) && $stable(last)))
    else $error("output item changed before it was taken");

endmodule
`default_nettype wire

/* verif/integer_to_ascii_radix_core_tb.sv */
// Testbench for integer_to_ascii_radix_core: directed and random values, checked char by char.
`timescale 1ns / 100ps
module integer_to_ascii_radix_core_tb;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } text_char_t;

  localparam int RANDOM_ITEMS = 140;
  localparam int IDLE_PCT     = 27;
  localparam int DRAIN_CYCLES = 128;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = i2a_pkg::MODE_SDEC;
  logic [63:0] value = 64'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  char_out;
  logic        last;

  text_char_t pending_text[$];
  int         error_count = 0;
  logic       steady = 1'b0;  // no idling on either side while set

  integer_to_ascii_radix_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_out  (char_out),
    .last      (last)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAIL integer_to_ascii_radix_core");
    $finish;
  end

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return i2a_pkg::CH_ZERO + {4'd0, d};
    end
    return 8'h61 + {4'd0, d} - 8'd10;  // 'a' and up
  endfunction

  function automatic void push_char(input logic [7:0] ch, input logic fin);
    text_char_t t;
    t.ch  = ch;
    t.fin = fin;
    pending_text.push_back(t);
  endfunction

  // Expected text for one item, appended to pending_text
  function automatic void predict_text(input logic [1:0] m, input logic [63:0] v);
    logic [63:0] mask;
    logic [63:0] x;
    logic [63:0] radix;
    logic [63:0] rem;
    logic        neg;
    logic [7:0]  digits[$];
    mask = (i2a_pkg::VALUE_WIDTH >= 64) ? {64{1'b1}}
                                        : ((64'd1 << i2a_pkg::VALUE_WIDTH) - 64'd1);
    x = v & mask;
    neg = 1'b0;
    if (m == i2a_pkg::MODE_PTR) begin
      push_char(i2a_pkg::CH_ZERO, 1'b0);
      push_char(i2a_pkg::CH_X, 1'b0);
      for (int i = 0; i < i2a_pkg::PTR_DIGITS; i++) begin
        push_char(digit_char(x[63:60]), i == i2a_pkg::PTR_DIGITS - 1);
        x = x << 4;
      end
      return;
    end
    radix = (m == i2a_pkg::MODE_HEX) ? 64'd16 : 64'd10;
    if (m == i2a_pkg::MODE_SDEC && x[i2a_pkg::VALUE_WIDTH-1]) begin
      neg = 1'b1;
      x = (~x + 64'd1) & mask;
      if (x == 64'd0) begin
        x = 64'd1 << (i2a_pkg::VALUE_WIDTH - 1);
      end
    end
    do begin
      rem = x % radix;
      digits.push_front(digit_char(rem[3:0]));
      x = x / radix;
    end while (x != 64'd0);
    if (neg) begin
      push_char(i2a_pkg::CH_MINUS, 1'b0);
    end
    foreach (digits[i]) begin
      push_char(digits[i], i == digits.size() - 1);
    end
  endfunction

  // Entered and left at a falling edge
  task automatic send_item(input logic [1:0] m, input logic [63:0] v);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid = 1'b1;
    mode     = m;
    value    = v;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predict_text(m, v);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready = steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : check_text
    text_char_t t;
    if (!rst && out_valid && out_ready) begin
      if (pending_text.size() == 0) begin
        report($sformatf("unexpected char 0x%02h last=%0b", char_out, last));
      end else begin
        t = pending_text.pop_front();
        if (char_out !== t.ch) begin
          report($sformatf("char_out 0x%02h, want 0x%02h", char_out, t.ch));
        end
        if (last !== t.fin) begin
          report($sformatf("last %0b, want %0b on char 0x%02h", last, t.fin, t.ch));
        end
      end
    end
  end

  task automatic test_signed_decimal();
    send_item(i2a_pkg::MODE_SDEC, 64'd0);
    send_item(i2a_pkg::MODE_SDEC, 64'd1);
    send_item(i2a_pkg::MODE_SDEC, {64{1'b1}});
    send_item(i2a_pkg::MODE_SDEC, 64'h7fff_ffff_ffff_ffff);
    send_item(i2a_pkg::MODE_SDEC, 64'h8000_0000_0000_0000);  // most negative
    send_item(i2a_pkg::MODE_SDEC, -64'sd10);
    send_item(i2a_pkg::MODE_SDEC, 64'd1234567890);
  endtask

  task automatic test_unsigned_decimal();
    send_item(i2a_pkg::MODE_UDEC, 64'd0);
    send_item(i2a_pkg::MODE_UDEC, 64'd9);
    send_item(i2a_pkg::MODE_UDEC, 64'd10);
    send_item(i2a_pkg::MODE_UDEC, {64{1'b1}});  // 20 digits
    send_item(i2a_pkg::MODE_UDEC, 64'd10_000_000_000_000_000_000);
  endtask

  task automatic test_hex();
    send_item(i2a_pkg::MODE_HEX, 64'd0);
    send_item(i2a_pkg::MODE_HEX, 64'hf);
    send_item(i2a_pkg::MODE_HEX, 64'h10);
    send_item(i2a_pkg::MODE_HEX, {64{1'b1}});
    send_item(i2a_pkg::MODE_HEX, 64'h0123_4567_89ab_cdef);
  endtask

  task automatic test_pointer();
    send_item(i2a_pkg::MODE_PTR, 64'd0);
    send_item(i2a_pkg::MODE_PTR, {64{1'b1}});
    send_item(i2a_pkg::MODE_PTR, 64'hdead_beef);
    send_item(i2a_pkg::MODE_PTR, 64'hfedc_ba98_7654_3210);
  endtask

  task automatic test_random_values();
    logic [63:0] v;
    logic [1:0]  m;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady = (i >= 60 && i < 100);
      m = 2'($urandom_range(3));
      case ($urandom_range(3))
        0: begin
          v = {$urandom, $urandom};
        end
        1: begin
          v = 64'($urandom_range(0, 1000));
        end
        2: begin
          v = -64'($urandom_range(1, 1000));
        end
        default: begin
          // spread the digit count
          v = {$urandom, $urandom} >> $urandom_range(0, 63);
        end
      endcase
      send_item(m, v);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_signed_decimal();
    test_unsigned_decimal();
    test_hex();
    test_pointer();
    test_random_values();
    in_valid = 1'b0;
    while (pending_text.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS integer_to_ascii_radix_core");
    end else begin
      $display("FAIL integer_to_ascii_radix_core");
    end
    $finish;
  end

endmodule
